// File: design/prefix_code_byte_packer_defines.svh
// Assertion macros for the prefix code byte packer.
// Included by the modules that carry concurrent checks.
`ifndef PREFIX_CODE_BYTE_PACKER_DEFINES_SVH
`define PREFIX_CODE_BYTE_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
`define PCBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("pcbp: assertion failed");
`define PCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("pcbp: assertion failed");
`else
`define PCBP_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PCBP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/pcbp_pkg.sv
// Shared types and constants for the prefix code byte packer.
// No dependencies.
`default_nettype none

package pcbp_pkg;

    localparam int NUM_REGS    = 4;
    localparam int MAX_ENTRIES = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 20;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 8;
    localparam int LEN_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    localparam logic [CFG_DATA_W-1:0] ENTRY_RESET [NUM_REGS] = '{
        20'd65605, 20'd131649, 20'd198228, 20'd198478
    };

    typedef enum logic [1:0] {
        KIND_FULL    = 2'd0,
        KIND_FLUSH   = 2'd1,
        KIND_UNKNOWN = 2'd2
    } kind_t;

    // classified request passed from front to back
    typedef struct packed {
        logic              found;
        logic              eom;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } cmd_t;

endpackage

`default_nettype wire

// File: design/pcbp_char_if.sv
// Input channel: one character request with end-of-message flag.
// Depends on nothing.
`default_nettype none

interface pcbp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       end_of_message;

    modport source (output valid, symbol, end_of_message, input ready);
    modport sink (input valid, symbol, end_of_message, output ready);
endinterface

`default_nettype wire

// File: design/pcbp_result_if.sv
// Output channel: one packed byte or status request.
// Depends on pcbp_pkg.
`default_nettype none

interface pcbp_result_if;
    logic              valid;
    logic              ready;
    pcbp_pkg::kind_t   kind;
    logic [7:0]        out_byte;
    logic              last_of_run;

    modport source (output valid, kind, out_byte, last_of_run, input ready);
    modport sink (input valid, kind, out_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// File: design/pcbp_front.sv
// Front end: code entry registers, symbol lookup and request classification.
// Depends on pcbp_pkg and pcbp_char_if.
`default_nettype none

module pcbp_front #(
    parameter int ENTRIES = pcbp_pkg::MAX_ENTRIES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pcbp_char_if.sink                            char_chan,
    input  wire logic                            cfg_we,
    input  wire logic [pcbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcbp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            queue_full,
    output logic                                 push,
    output pcbp_pkg::cmd_t                       push_cmd
);

    logic [pcbp_pkg::CFG_DATA_W-1:0] entry_reg [ENTRIES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_reg[i] <= pcbp_pkg::ENTRY_RESET[i];
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (cfg_we && cfg_index == pcbp_pkg::CFG_IDX_W'(i))
                begin
                    entry_reg[i] <= cfg_data;
                end
            end
        end
    end

    assign char_chan.ready = !queue_full;
    assign push            = char_chan.valid && !queue_full;

    // first enabled matching entry wins
    always_comb
    begin
        logic [pcbp_pkg::LEN_W-1:0]  len;
        logic [pcbp_pkg::CODE_W-1:0] mask;
        push_cmd       = '0;
        push_cmd.eom   = char_chan.end_of_message;
        len            = '0;
        mask           = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            len = entry_reg[i][19:16];
            if (!push_cmd.found && len != '0 && entry_reg[i][7:0] == char_chan.symbol)
            begin
                if (len > pcbp_pkg::MAX_LEN)
                begin
                    len = pcbp_pkg::MAX_LEN;
                end
                mask           = 8'hFF >> (pcbp_pkg::MAX_LEN - len);
                push_cmd.found = 1'b1;
                push_cmd.len   = len;
                push_cmd.code  = entry_reg[i][15:8] & mask;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/pcbp_queue.sv
// Short request queue between front and back.
// Depends on pcbp_pkg and prefix_code_byte_packer_defines.svh.
`default_nettype none

`include "prefix_code_byte_packer_defines.svh"

module pcbp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pcbp_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                head_valid,
    output pcbp_pkg::cmd_t      head
);

    localparam int PTR_W = $clog2(pcbp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(pcbp_pkg::QUEUE_DEPTH + 1);

    pcbp_pkg::cmd_t   mem [pcbp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == CNT_W'(pcbp_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= PTR_W'((wr_ptr_reg + 1'b1) % pcbp_pkg::QUEUE_DEPTH);
            end
            if (pop)
            begin
                rd_ptr_reg <= PTR_W'((rd_ptr_reg + 1'b1) % pcbp_pkg::QUEUE_DEPTH);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    `PCBP_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(pcbp_pkg::QUEUE_DEPTH))
    `PCBP_ASSERT_IMPL(a_no_push_full, clk, rst_n, full, !push)

endmodule

`default_nettype wire

// File: design/pcbp_back.sv
// Back end: bit packer, flush sequencing and registered result output.
// Depends on pcbp_pkg, pcbp_result_if and prefix_code_byte_packer_defines.svh.
`default_nettype none

`include "prefix_code_byte_packer_defines.svh"

module pcbp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire pcbp_pkg::cmd_t head,
    output logic                pop,
    pcbp_result_if.source       result_chan
);

    logic [7:0]      bits_reg;
    logic [7:0]      bits_next;
    logic [2:0]      count_reg;
    logic [2:0]      count_next;
    logic            phase_reg;
    logic            phase_next;
    logic            out_valid_reg;
    pcbp_pkg::kind_t out_kind_reg;
    logic [7:0]      out_byte_reg;
    logic            out_last_reg;

    logic            can_load;
    logic            emit;
    pcbp_pkg::kind_t e_kind;
    logic [7:0]      e_byte;
    logic            e_last;

    logic [15:0]     acc;
    logic [3:0]      total;
    logic            full_byte;
    logic [7:0]      packed_byte;
    logic [7:0]      nb;
    logic [2:0]      nc;
    logic            r1;
    logic            rf;

    logic            out_flush;
    logic            out_unknown;

    assign can_load = !out_valid_reg || result_chan.ready;

    assign acc         = ({8'd0, bits_reg} << head.len) | {8'd0, head.code};
    assign total       = {1'b0, count_reg} + head.len;
    assign full_byte   = head.found && total[3];
    assign packed_byte = 8'(acc >> total[2:0]);
    assign nb = head.found ? (acc[7:0] & (8'hFF >> (4'd8 - {1'b0, total[2:0]}))) : bits_reg;
    assign nc = head.found ? total[2:0] : count_reg;
    assign r1 = !head.found || full_byte;
    assign rf = head.eom && nc != 3'd0;

    always_comb
    begin
        emit       = 1'b0;
        e_kind     = pcbp_pkg::KIND_FULL;
        e_byte     = '0;
        e_last     = 1'b0;
        pop        = 1'b0;
        phase_next = phase_reg;
        bits_next  = bits_reg;
        count_next = count_reg;
        if (head_valid && can_load)
        begin
            if (phase_reg)
            begin
                emit       = 1'b1;
                e_kind     = pcbp_pkg::KIND_FLUSH;
                e_byte     = bits_reg << (4'd8 - {1'b0, count_reg});
                e_last     = 1'b1;
                pop        = 1'b1;
                phase_next = 1'b0;
                bits_next  = '0;
                count_next = '0;
            end
            else if (r1)
            begin
                emit   = 1'b1;
                e_kind = head.found ? pcbp_pkg::KIND_FULL : pcbp_pkg::KIND_UNKNOWN;
                e_byte = head.found ? packed_byte : 8'd0;
                e_last = !rf;
                if (rf)
                begin
                    phase_next = 1'b1;
                    bits_next  = nb;
                    count_next = nc;
                end
                else
                begin
                    pop        = 1'b1;
                    bits_next  = head.eom ? 8'd0 : nb;
                    count_next = head.eom ? 3'd0 : nc;
                end
            end
            else
            begin
                pop        = 1'b1;
                bits_next  = head.eom ? 8'd0 : nb;
                count_next = head.eom ? 3'd0 : nc;
                if (rf)
                begin
                    emit   = 1'b1;
                    e_kind = pcbp_pkg::KIND_FLUSH;
                    e_byte = nb << (4'd8 - {1'b0, nc});
                    e_last = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg      <= '0;
            count_reg     <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bits_reg  <= bits_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
            if (can_load)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && emit)
        begin
            out_kind_reg <= e_kind;
            out_byte_reg <= e_byte;
            out_last_reg <= e_last;
        end
    end

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.kind        = out_kind_reg;
    assign result_chan.out_byte    = out_byte_reg;
    assign result_chan.last_of_run = out_last_reg;

    assign out_flush   = out_valid_reg && out_kind_reg == pcbp_pkg::KIND_FLUSH && out_last_reg;
    assign out_unknown = out_valid_reg && out_kind_reg == pcbp_pkg::KIND_UNKNOWN;

    `PCBP_ASSERT_IMPL(a_phase_head, clk, rst_n, phase_reg, head_valid)
    `PCBP_ASSERT_NEXT(a_phase_flush, clk, rst_n, phase_reg && can_load, out_flush)
    `PCBP_ASSERT_IMPL(a_unknown_zero, clk, rst_n, out_unknown, out_byte_reg == 8'd0)
    `PCBP_ASSERT_NEXT(a_eom_clears, clk, rst_n, pop && head.eom, count_reg == 3'd0 && !phase_reg)

endmodule

`default_nettype wire

// File: design/prefix_code_byte_packer.sv
// A request passes the queue, and its result is held in the output register.
// Throughput: one character per cycle when the queue has room and the output
// is ready; a character's second result, its padded flush byte, holds the packer.
// The output register and the two-entry queue let input and output stall apart.
// Reset: queue, packer and output valid clear; code entries take their defaults.
`default_nettype none

module prefix_code_byte_packer #(
    parameter int ENTRIES = pcbp_pkg::MAX_ENTRIES
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pcbp_char_if.sink                            char_chan,
    pcbp_result_if.source                        result_chan,
    input  wire logic                            cfg_we,
    input  wire logic [pcbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcbp_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic           push;
    pcbp_pkg::cmd_t push_cmd;
    logic           queue_full;
    logic           pop;
    logic           head_valid;
    pcbp_pkg::cmd_t head;

    pcbp_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_chan),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    pcbp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    pcbp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

`default_nettype wire

// File: verif/tb_prefix_code_byte_packer.sv
// Testbench for prefix_code_byte_packer: code table lookup, MSB-first byte packing,
// padded flush and unknown-symbol results, checked against an in-bench encoder.
// Depends on pcbp_pkg, pcbp_char_if, pcbp_result_if and the packer itself.
module tb_prefix_code_byte_packer;
    import pcbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_3 = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        logic [7:0] symbol;
        logic       eom;
    } char_req_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last_of_run;
    } code_byte_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pcbp_char_if   char_chan ();
    pcbp_result_if result_chan ();

    prefix_code_byte_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_chan   (char_chan),
        .result_chan (result_chan),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // encoder state mirrored from the block
    logic [CFG_DATA_W-1:0] code_table [NUM_REGS];
    logic [7:0] pack_bits;
    int pack_count;

    char_req_t  pending_chars [$];
    code_byte_t expected_bytes [$];

    int  mismatches;
    int  cycle_count;
    int  char_gap_max;
    int  result_stall_max;
    int  char_wait;
    int  result_wait;
    bit  char_busy;
    bit  char_taken;
    bit  result_taken;

    function automatic logic [CFG_DATA_W-1:0] make_entry(input logic [3:0] len,
                                                        input logic [7:0] code,
                                                        input logic [7:0] sym);
        return {len, code, sym};
    endfunction

    function automatic void encode_symbol(input logic [7:0] sym, input logic eom);
        int len;
        int produced;
        bit found;
        logic [CFG_DATA_W-1:0] ent;
        found = 1'b0;
        produced = 0;
        for (int r = 0; r < MAX_ENTRIES; r++) begin
            ent = code_table[r];
            len = ent[19:16];
            if (!found && len != 0 && ent[7:0] == sym) begin
                found = 1'b1;
                if (len > MAX_LEN)
                    len = MAX_LEN;
                for (int b = len - 1; b >= 0; b--) begin
                    pack_bits = {pack_bits[6:0], ent[8 + b]};
                    pack_count++;
                    if (pack_count == 8) begin
                        expected_bytes.push_back('{KIND_FULL, pack_bits, 1'b0});
                        produced++;
                        pack_bits = '0;
                        pack_count = 0;
                    end
                end
            end
        end
        if (!found) begin
            expected_bytes.push_back('{KIND_UNKNOWN, 8'h00, 1'b0});
            produced++;
        end
        if (eom) begin
            if (pack_count > 0) begin
                expected_bytes.push_back('{KIND_FLUSH, 8'(pack_bits << (8 - pack_count)),
                                           1'b0});
                produced++;
            end
            pack_bits = '0;
            pack_count = 0;
        end
        if (produced > 0)
            expected_bytes[expected_bytes.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // prediction and checking
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        else if (!rst_n) begin
            for (int r = 0; r < NUM_REGS; r++)
                code_table[r] = ENTRY_RESET[r];
            pack_bits = '0;
            pack_count = 0;
            char_taken <= 1'b0;
            result_taken <= 1'b0;
        end
        else begin
            if (cfg_we)
                code_table[cfg_index] = cfg_data;
            char_taken <= char_chan.valid && char_chan.ready;
            result_taken <= result_chan.valid && result_chan.ready;
            if (char_chan.valid && char_chan.ready)
                encode_symbol(char_chan.symbol, char_chan.end_of_message);
            if (result_chan.valid && result_chan.ready) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                             $time, result_chan.kind, result_chan.out_byte);
                end
                else begin
                    code_byte_t want;
                    want = expected_bytes.pop_front();
                    check_field("kind", want.kind, result_chan.kind);
                    check_field("out_byte", want.value, result_chan.out_byte);
                    check_field("last_of_run", want.last_of_run, result_chan.last_of_run);
                end
            end
        end
    end

    // character request driver
    always @(negedge clk)
    begin
        if (!rst_n) begin
            char_chan.valid <= 1'b0;
        end
        else begin
            char_req_t req;
            if (char_busy && char_taken)
                char_busy = 1'b0;
            if (!char_busy) begin
                if (char_wait > 0)
                    char_wait--;
                else if (pending_chars.size() > 0) begin
                    req = pending_chars.pop_front();
                    char_chan.symbol <= req.symbol;
                    char_chan.end_of_message <= req.eom;
                    char_busy = 1'b1;
                    char_wait = $urandom_range(0, char_gap_max);
                end
            end
            char_chan.valid <= char_busy;
        end
    end

    // result ready with random stalls
    always @(negedge clk)
    begin
        if (!rst_n) begin
            result_chan.ready <= 1'b0;
        end
        else begin
            if (result_taken)
                result_wait = $urandom_range(0, result_stall_max);
            if (result_wait > 0) begin
                result_wait--;
                result_chan.ready <= 1'b0;
            end
            else begin
                result_chan.ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic [7:0] sym, input logic eom);
        pending_chars.push_back('{sym, eom});
    endtask

    task automatic drain();
        while (pending_chars.size() != 0 || char_busy || expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_table(input logic [CFG_DATA_W-1:0] e0, input logic [CFG_DATA_W-1:0] e1,
                              input logic [CFG_DATA_W-1:0] e2, input logic [CFG_DATA_W-1:0] e3);
        logic [CFG_DATA_W-1:0] vals [NUM_REGS];
        logic [CFG_IDX_W-1:0] regs [NUM_REGS];
        vals = '{e0, e1, e2, e3};
        regs = '{REG_ENTRY_0, REG_ENTRY_1, REG_ENTRY_2, REG_ENTRY_3};
        for (int r = 0; r < NUM_REGS; r++) begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= regs[r];
            cfg_data <= vals[r];
            @(negedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic pick_idling();
        int pick;
        pick = $urandom_range(0, 2);
        char_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;
        pick = $urandom_range(0, 2);
        result_stall_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 15;
    endtask

    // messages of table symbols ending in eom, with some noise and broken framing
    task automatic queue_messages(input int count);
        int left;
        int msg_len;
        logic [7:0] sym;
        logic eom;
        left = count;
        while (left > 0) begin
            msg_len = $urandom_range(1, 12);
            if (msg_len > left)
                msg_len = left;
            for (int i = 0; i < msg_len; i++) begin
                if ($urandom_range(0, 99) < 85)
                    sym = code_table[$urandom_range(0, NUM_REGS - 1)][7:0];
                else
                    sym = 8'($urandom);
                eom = (i == msg_len - 1);
                if ($urandom_range(0, 19) == 0)
                    eom = ~eom;
                send(sym, eom);
            end
            left -= msg_len;
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_entry(input logic [7:0] alias_sym);
        logic [3:0] len;
        logic [7:0] sym;
        if ($urandom_range(0, 9) < 7)
            len = 4'($urandom_range(1, 8));
        else
            len = 4'($urandom_range(0, 15));
        sym = ($urandom_range(0, 4) == 0) ? alias_sym : 8'($urandom);
        return make_entry(len, 8'($urandom), sym);
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] e0, e1, e2, e3;
        mismatches = 0;
        cycle_count = 0;
        char_gap_max = 0;
        result_stall_max = 0;
        char_wait = 0;
        result_wait = 0;
        char_busy = 1'b0;
        char_chan.valid = 1'b0;
        char_chan.symbol = '0;
        char_chan.end_of_message = 1'b0;
        result_chan.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default table: E=0, A=10, T=110, N=111
        pick_idling();
        send("E", 1'b0);
        send("A", 1'b0);
        send("N", 1'b0);
        send("T", 1'b0);
        send(8'h00, 1'b0);
        send(8'hFF, 1'b1);
        send("E", 1'b1);
        send("N", 1'b0);
        send("N", 1'b0);
        send("A", 1'b1);
        send(8'h80, 1'b1);
        send("N", 1'b0);
        send("N", 1'b0);
        send("N", 1'b1);
        send("a", 1'b0);
        send("T", 1'b0);
        send("E", 1'b0);
        send(8'h7F, 1'b1);
        drain();

        // disabled entry skipped, duplicate symbols, overlong length
        load_table(make_entry(4'd0, 8'hFF, "E"), make_entry(4'd8, 8'hA5, "E"),
                   make_entry(4'd15, 8'hFF, 8'h00), make_entry(4'd1, 8'h01, 8'h00));
        pick_idling();
        send("E", 1'b0);
        send(8'h00, 1'b0);
        send("E", 1'b1);
        send(8'h00, 1'b1);
        queue_messages(26);
        drain();

        // all fields at their maximum
        load_table('1, '1, '1, '1);
        pick_idling();
        send(8'hFF, 1'b0);
        send(8'hFF, 1'b1);
        queue_messages(18);
        drain();

        // every entry disabled
        load_table('0, '0, '0, '0);
        pick_idling();
        send(8'h00, 1'b1);
        queue_messages(14);
        drain();

        for (int p = 0; p < 8; p++) begin
            e0 = random_entry(8'($urandom));
            e1 = random_entry(e0[7:0]);
            e2 = random_entry(e1[7:0]);
            e3 = random_entry(e0[7:0]);
            load_table(e0, e1, e2, e3);
            pick_idling();
            queue_messages(58);
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+design
design/pcbp_pkg.sv
design/pcbp_char_if.sv
design/pcbp_result_if.sv
design/pcbp_front.sv
design/pcbp_queue.sv
design/pcbp_back.sv
design/prefix_code_byte_packer.sv
verif/tb_prefix_code_byte_packer.sv
